>>> rtl/core/infix_to_postfix_converter_top_defines.svh
// Assertion helpers shared by the converter RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define I2P_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/i2p_pkg.sv
`default_nettype none

package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    // Operator codes as held on the stack
    typedef enum logic [2:0]
    {
        OP_LPAREN = 3'd0,
        OP_PLUS   = 3'd1,
        OP_MINUS  = 3'd2,
        OP_TIMES  = 3'd3,
        OP_DIVIDE = 3'd4
    } op_code_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DIVIDE = 8'h2F;
    localparam logic [7:0] CH_TERM   = 8'h00;

    // Stack port controls
    typedef struct packed
    {
        logic     wr_en;
        logic     rd_en;
        op_code_t wr_data;
    } stk_ctl_t;

    function automatic logic [1:0] op_rank(op_code_t c);
        case (c)
            OP_PLUS, OP_MINUS:  op_rank = 2'd1;
            OP_TIMES, OP_DIVIDE: op_rank = 2'd2;
            default:            op_rank = 2'd0;
        endcase
    endfunction

    function automatic logic [7:0] op_char(op_code_t c);
        case (c)
            OP_LPAREN: op_char = CH_LPAREN;
            OP_PLUS:   op_char = CH_PLUS;
            OP_MINUS:  op_char = CH_MINUS;
            OP_TIMES:  op_char = CH_TIMES;
            OP_DIVIDE: op_char = CH_DIVIDE;
            default:   op_char = CH_TERM;
        endcase
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        is_alnum = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_op(logic [7:0] c);
        is_op = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_TIMES) ||
                (c == CH_DIVIDE);
    endfunction

    function automatic op_code_t op_of(logic [7:0] c);
        case (c)
            CH_PLUS:  op_of = OP_PLUS;
            CH_MINUS: op_of = OP_MINUS;
            CH_TIMES: op_of = OP_TIMES;
            default:  op_of = OP_DIVIDE;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/infix_to_postfix_converter_top.sv
`default_nettype none

// Shunting-yard infix to postfix converter. One expression character (kind 0)
// or an end marker (kind 1) is taken per input transfer. Letters and digits
// come straight back out; '(' and the four operators go to an operator stack
// of STACK_DEPTH entries; ')' and operators pop stacked operators out first;
// the end marker pops everything and closes with a zero terminator that
// carries the sticky unmatched-')' and dropped-push flags, after which both
// flags clear. Other characters produce nothing. 'last' marks the final
// result of each input item. Steps: an input item is taken in idle and then
// decoded; a letter, digit, '(' or ignored character is then done; ')', an
// operator or a flush then spend a read step (registered stack read) and a
// compare step (compare and emit) on each stack pop, plus a final check: a
// read step when the stack is or becomes empty, or a read and a compare step
// when the pops stop at a '(' or a lower-ranked operator. A result that has
// to wait for the output register to free up stalls these steps. The stack
// has one write port and one registered read port, and that registered read
// is why each pop needs both steps.
// The block takes a new item while its last result is still waiting on the
// output register; it does not accept while an item is in progress.

`include "infix_to_postfix_converter_top_defines.svh"

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last,
    output logic       err_unmatched,
    output logic       err_overflow
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DEC,     // classify latched character
        ST_RD,      // issue stack read, or finish on empty stack
        ST_CMP      // compare top of stack, pop or stop
    } state_t;

    typedef enum logic [1:0]
    {
        MODE_CLOSE,
        MODE_OP,
        MODE_FLUSH
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic               kind_reg, kind_next;
    logic [7:0]         ch_reg, ch_next;
    i2p_pkg::op_code_t  op_reg, op_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               unmatched_reg, unmatched_next;
    logic               overflow_reg, overflow_next;
    // Pop held back until we know whether it is the last result
    logic               hold_valid_reg, hold_valid_next;
    logic [7:0]         hold_char_reg, hold_char_next;
    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               out_eu_reg, out_eu_next;
    logic               out_eo_reg, out_eo_next;

    i2p_pkg::stk_ctl_t  stk_ctl;
    i2p_pkg::op_code_t  top_code;
    logic [CW-1:0]      count_m1;
    logic [AW-1:0]      stk_rd_addr;
    logic [AW-1:0]      stk_wr_addr;
    logic               out_free;
    logic               full;
    logic               do_pop;
    logic               can_finish;

    i2p_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .ctl     (stk_ctl),
        .wr_addr (stk_wr_addr),
        .rd_addr (stk_rd_addr),
        .rd_data (top_code)
    );

    assign count_m1    = count_reg - 1'b1;
    assign stk_rd_addr = count_m1[AW-1:0];
    assign stk_wr_addr = count_reg[AW-1:0];
    assign full        = (count_reg == CW'(STACK_DEPTH));
    assign out_free    = !out_valid_reg || out_ready;
    // Finishing with a held pop needs the output register
    assign can_finish  = !hold_valid_reg || out_free;

    assign do_pop = (mode_reg == MODE_FLUSH) ||
                    ((top_code != i2p_pkg::OP_LPAREN) &&
                     ((mode_reg == MODE_CLOSE) ||
                      (i2p_pkg::op_rank(top_code) >= i2p_pkg::op_rank(op_reg))));

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        ch_next         = ch_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        unmatched_next  = unmatched_reg;
        overflow_next   = overflow_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_eu_next     = out_eu_reg;
        out_eo_next     = out_eo_reg;
        stk_ctl.wr_en   = 1'b0;
        stk_ctl.rd_en   = 1'b0;
        stk_ctl.wr_data = op_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    ch_next    = ch;
                    state_next = ST_DEC;
                end
            end

            ST_DEC:
            begin
                if (kind_reg)
                begin
                    mode_next  = MODE_FLUSH;
                    state_next = ST_RD;
                end
                else if (i2p_pkg::is_alnum(ch_reg))
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = ch_reg;
                        out_last_next  = 1'b1;
                        out_eu_next    = 1'b0;
                        out_eo_next    = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (ch_reg == i2p_pkg::CH_LPAREN)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        stk_ctl.wr_en   = 1'b1;
                        stk_ctl.wr_data = i2p_pkg::OP_LPAREN;
                        count_next      = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (ch_reg == i2p_pkg::CH_RPAREN)
                begin
                    mode_next  = MODE_CLOSE;
                    state_next = ST_RD;
                end
                else if (i2p_pkg::is_op(ch_reg))
                begin
                    op_next    = i2p_pkg::op_of(ch_reg);
                    mode_next  = MODE_OP;
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_RD:
            begin
                if (count_reg != '0)
                begin
                    stk_ctl.rd_en = 1'b1;
                    state_next    = ST_CMP;
                end
                else if (mode_reg == MODE_FLUSH)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = i2p_pkg::CH_TERM;
                        out_last_next  = 1'b1;
                        out_eu_next    = unmatched_reg;
                        out_eo_next    = overflow_reg;
                        unmatched_next = 1'b0;
                        overflow_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (can_finish)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = hold_char_reg;
                        out_last_next  = 1'b1;
                        out_eu_next    = 1'b0;
                        out_eo_next    = 1'b0;
                    end
                    hold_valid_next = 1'b0;
                    if (mode_reg == MODE_CLOSE)
                    begin
                        unmatched_next = 1'b1;
                    end
                    else
                    begin
                        // empty stack, never full here
                        stk_ctl.wr_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_CMP:
            begin
                if (do_pop)
                begin
                    if (mode_reg == MODE_FLUSH)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = i2p_pkg::op_char(top_code);
                            out_last_next  = 1'b0;
                            out_eu_next    = 1'b0;
                            out_eo_next    = 1'b0;
                            count_next     = count_m1;
                            state_next     = ST_RD;
                        end
                    end
                    else if (can_finish)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = hold_char_reg;
                            out_last_next  = 1'b0;
                            out_eu_next    = 1'b0;
                            out_eo_next    = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_char_next  = i2p_pkg::op_char(top_code);
                        count_next      = count_m1;
                        state_next      = ST_RD;
                    end
                end
                else if (can_finish)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = hold_char_reg;
                        out_last_next  = 1'b1;
                        out_eu_next    = 1'b0;
                        out_eo_next    = 1'b0;
                    end
                    hold_valid_next = 1'b0;
                    if (mode_reg == MODE_CLOSE)
                    begin
                        // matching '(' dropped
                        count_next = count_m1;
                    end
                    else if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        stk_ctl.wr_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_CLOSE;
            count_reg      <= '0;
            unmatched_reg  <= 1'b0;
            overflow_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            unmatched_reg  <= unmatched_next;
            overflow_reg   <= overflow_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        ch_reg        <= ch_next;
        op_reg        <= op_next;
        hold_char_reg <= hold_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_eu_reg    <= out_eu_next;
        out_eo_reg    <= out_eo_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign last          = out_last_reg;
    assign err_unmatched = out_eu_reg;
    assign err_overflow  = out_eo_reg;

    `I2P_ASSERT_IMPL(a_count_bound, 1'b1,
        count_reg <= CW'(STACK_DEPTH),
        "stack count past depth")
    `I2P_ASSERT_IMPL(a_flags_on_term, out_valid && (err_unmatched || err_overflow),
        (out_char == i2p_pkg::CH_TERM) && last,
        "error flag off terminator")
    `I2P_ASSERT_NEXT(a_pop_dec, (state_reg == ST_CMP) && (state_next == ST_RD),
        count_reg == CW'($past(count_reg) - 1'b1),
        "pop did not shrink stack")
    `I2P_ASSERT_NEXT(a_flush_clear,
        (state_reg == ST_RD) && (mode_reg == MODE_FLUSH) && (count_reg == '0) && out_free,
        !unmatched_reg && !overflow_reg && out_valid && last,
        "flush did not close cleanly")

endmodule

`default_nettype wire

>>> rtl/core/i2p_stack.sv
`default_nettype none

// Operator stack storage: one write port, one registered read port.
module i2p_stack #(
    parameter int DEPTH = i2p_pkg::STACK_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               clk,
    input  i2p_pkg::stk_ctl_t  ctl,
    input  logic [AW-1:0]      wr_addr,
    input  logic [AW-1:0]      rd_addr,
    output i2p_pkg::op_code_t  rd_data
);

    logic [2:0] stack_mem [DEPTH];
    logic [2:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            stack_mem[wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign rd_data = i2p_pkg::op_code_t'(rd_data_reg);

endmodule

`default_nettype wire
